FILE: sv/i2ad_pkg.sv
// ----------------------------------------------------------------------------
// i2ad_pkg
// Types and constants shared by the binary to ASCII number formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2ad_pkg;

  // operand and digit geometry
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned DEC_DIGITS = 20;
  localparam int unsigned BCD_W      = DEC_DIGITS * 4;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned STEP_W     = 6;

  // mode codes
  localparam logic [1:0] CMD_UDEC = 2'd0;
  localparam logic [1:0] CMD_SDEC = 2'd1;
  localparam logic [1:0] CMD_HEX  = 2'd2;

  // character codes
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  // input item
  typedef struct packed {
    logic [1:0]         cmd;
    logic [VALUE_W-1:0] value;
  } req_t;

  // result item
  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } res_t;

  // status of the shift-add-3 unit
  typedef struct packed {
    logic busy;
    logic done;
  } dabble_stat_t;

  // nibble to lowercase hex character
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] code;
    if (nib < 4'd10) begin
      code = 8'h30 + {4'd0, nib};
    end else begin
      code = 8'h57 + {4'd0, nib};
    end
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: sv/i2ad_dabble.sv
// ----------------------------------------------------------------------------
// i2ad_dabble
// Shift-add-3 binary to BCD unit, one operand bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module i2ad_dabble (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             load,
  input  wire logic [i2ad_pkg::VALUE_W-1:0]     bin,
  output i2ad_pkg::dabble_stat_t                stat,
  output logic      [i2ad_pkg::BCD_W-1:0]       bcd
);
  import i2ad_pkg::*;

  logic [VALUE_W-1:0] shreg;
  logic [STEP_W-1:0]  step;
  logic               run;
  logic               done;
  logic [BCD_W-1:0]   adj;

  // add 3 to every digit that is 5 or more
  always_comb begin
    for (int d = 0; d < DEC_DIGITS; d++) begin
      if (bcd[d*4 +: 4] >= 4'd5) begin
        adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
      end else begin
        adj[d*4 +: 4] = bcd[d*4 +: 4];
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run  <= 1'b0;
      step <= '0;
    end else if (load) begin
      run  <= 1'b1;
      step <= '0;
    end else if (run) begin
      step <= step + STEP_W'(1);
      if (step == STEP_W'(VALUE_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath: shift one bit into the digits
  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= bin;
      bcd   <= '0;
    end else if (run) begin
      bcd   <= {adj[BCD_W-2:0], shreg[VALUE_W-1]};
      shreg <= {shreg[VALUE_W-2:0], 1'b0};
    end
  end

  assign stat.busy = run;
  assign stat.done = done;

endmodule

`default_nettype wire

FILE: sv/int64_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// int64_to_ascii_digits
// Formats a 64-bit operand as ASCII decimal or hex, one character per result.
// ----------------------------------------------------------------------------
// Decimal: shift-add-3 over all 64 operand bits, then the digits are loaded,
//   a minus sign goes out if negative and up to 19 leading zeros are skipped.
// Hex: HEX_NIBBLES characters after the accept, from the top nibble down.
// Throughput: one item at a time; busy falls as the last strobe rises.
// Results leave on strobe for one cycle each; the receiver cannot stall.
// Reset (rst, synchronous) returns the sequencer to idle and drops strobe.
`default_nettype none

module int64_to_ascii_digits #(
  parameter int unsigned HEX_NIBBLES = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire i2ad_pkg::req_t request,
  output logic               strobe,
  output i2ad_pkg::res_t     result
);
  import i2ad_pkg::*;

  localparam int unsigned HEX_W = HEX_NIBBLES * 4;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SIGN = 5'b00100,
    S_SKIP = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t             state;
  logic [BCD_W-1:0]   digs;
  logic [CNT_W-1:0]   cnt;
  logic               neg;
  logic               accept;
  logic               dab_load;
  logic [VALUE_W-1:0] mag;
  dabble_stat_t       dab_stat;
  logic [BCD_W-1:0]   dab_bcd;
  logic [3:0]         top_nib;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign top_nib  = digs[BCD_W-1 -: 4];

  // magnitude for decimal modes
  always_comb begin
    mag = request.value;
    if (request.cmd == CMD_SDEC && request.value[VALUE_W-1]) begin
      mag = '0 - request.value;
    end
  end

  assign dab_load = accept && (request.cmd == CMD_UDEC || request.cmd == CMD_SDEC);

  i2ad_dabble u_dabble (
    .clk  (clk),
    .rst  (rst),
    .load (dab_load),
    .bin  (mag),
    .stat (dab_stat),
    .bcd  (dab_bcd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (request.cmd)
              CMD_UDEC, CMD_SDEC: state <= S_CONV;
              CMD_HEX:            state <= S_EMIT;
              default:            state <= S_IDLE;
            endcase
          end
        end
        S_CONV: begin
          if (dab_stat.done) begin
            state <= neg ? S_SIGN : S_SKIP;
          end
        end
        S_SIGN: begin
          strobe <= 1'b1;
          state  <= S_SKIP;
        end
        S_SKIP: begin
          if (!(top_nib == 4'd0 && cnt > CNT_W'(1))) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          strobe <= 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // digit register, count and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          neg  <= (request.cmd == CMD_SDEC) && request.value[VALUE_W-1];
          digs <= {request.value[HEX_W-1:0], {(BCD_W - HEX_W){1'b0}}};
          cnt  <= CNT_W'(HEX_NIBBLES);
        end
      end
      S_CONV: begin
        if (dab_stat.done) begin
          digs <= dab_bcd;
          cnt  <= CNT_W'(DEC_DIGITS);
        end
      end
      S_SIGN: begin
        result.char_code <= CHAR_MINUS;
        result.last      <= 1'b0;
      end
      S_SKIP: begin
        if (top_nib == 4'd0 && cnt > CNT_W'(1)) begin
          digs <= {digs[BCD_W-5:0], 4'd0};
          cnt  <= cnt - CNT_W'(1);
        end
      end
      S_EMIT: begin
        result.char_code <= hex_char(top_nib);
        result.last      <= (cnt == CNT_W'(1));
        digs             <= {digs[BCD_W-5:0], 4'd0};
        cnt              <= cnt - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire
